@@ design/best_fit_hole_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Best-fit hole allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_HOLE_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HOLE_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BFHA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/bfha_pkg.sv @@
// ----------------------------------------------------------------------------
// bfha_pkg
// Sizes and controller/datapath interface types of the best-fit hole allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int HOLES     = 64;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(HOLES);
  localparam int CNT_W     = $clog2(HOLES) + 1;

  localparam logic [CNT_W-1:0] HOLES_CNT = CNT_W'(HOLES);

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic load;    // write one hole size from the accepted item
    logic start;   // latch a request and clear the running best
    logic issue;   // read the table entry at the scan address
    logic finish;  // write back the chosen hole and load the result
  } bfha_cmd_t;

  typedef struct packed {
    logic last_issue;  // scan address is the last entry in use
    logic limit_zero;  // no entries in use
    logic out_free;    // result register can take a new item
  } bfha_stat_t;

endpackage

@@ design/bfha_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfha_ctrl
// Sequencer for load, table scan, write-back and result hand-off.
// ----------------------------------------------------------------------------
`include "best_fit_hole_allocator_macros.svh"

module bfha_ctrl
  import bfha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  input  bfha_stat_t stat_i,
  output bfha_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } bfha_state_t;

  bfha_state_t state_r, state_nxt;
  logic        accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd_o        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action) begin
            cmd_o.start = 1'b1;
            state_nxt   = stat_i.limit_zero ? S_FIN : S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last read is compared here.
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BFHA_ASSERT_NXT(a_scan_ends_in_drain, (state_r == S_SCAN) && stat_i.last_issue, state_r == S_DRAIN, "scan did not end in drain")
  `BFHA_ASSERT_NXT(a_fin_holds_when_busy, (state_r == S_FIN) && !stat_i.out_free, state_r == S_FIN, "result lost while output busy")
  `BFHA_ASSERT_IMP(a_cmds_exclusive, 1'b1, $countones(cmd_o) <= 1, "more than one command at once")

endmodule

@@ design/bfha_dp.sv @@
// ----------------------------------------------------------------------------
// bfha_dp
// Hole table, scan address, best-fit compare and result register.
// ----------------------------------------------------------------------------
`include "best_fit_hole_allocator_macros.svh"

module bfha_dp
  import bfha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bfha_cmd_t  cmd_i,
  output bfha_stat_t stat_o,
  input  logic       cfg_valid,
  input  cnt_t       cfg_data,
  input  idx_t       in_hole_index,
  input  size_t      in_size_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output idx_t       out_alloc_index,
  output size_t      out_left_size
);

  size_t hole_mem [HOLES];

  cnt_t  hole_count_r;
  cnt_t  limit;
  size_t req_size_r;
  idx_t  addr_r;
  size_t rd_data_r;
  idx_t  cmp_idx_r;
  logic  cmp_valid_r;
  logic  have_r;
  idx_t  best_idx_r;
  size_t best_size_r;
  size_t left;
  logic  better;
  logic  mem_we;
  idx_t  mem_waddr;
  size_t mem_wdata;
  logic  out_valid_r;
  logic  out_found_r;
  idx_t  out_idx_r;
  size_t out_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_count_r <= '0;
    end else if (cfg_valid) begin
      hole_count_r <= cfg_data;
    end
  end

  assign limit = (hole_count_r > HOLES_CNT) ? HOLES_CNT : hole_count_r;

  assign stat_o.limit_zero = (limit == '0);
  assign stat_o.last_issue = ({1'b0, addr_r} == (limit - cnt_t'(1)));
  assign stat_o.out_free   = !out_valid_r || out_ready;

  assign left = best_size_r - req_size_r;

  // Loads and the write-back share the single write port; they never coincide.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_hole_index;
    mem_wdata = in_size_value;
    if (cmd_i.load) begin
      mem_we = ({1'b0, in_hole_index} < HOLES_CNT);
    end else if (cmd_i.finish && have_r) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_r;
      mem_wdata = left;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hole_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.issue) begin
      rd_data_r <= hole_mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (cmd_i.start) begin
      req_size_r <= in_size_value;
      addr_r     <= '0;
    end else if (cmd_i.issue) begin
      addr_r <= addr_r + idx_t'(1);
    end
  end

  // Strict less-than keeps the lowest index among equal sizes.
  assign better = cmp_valid_r && (rd_data_r >= req_size_r) &&
                  (!have_r || (rd_data_r < best_size_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      cmp_valid_r <= cmd_i.issue;
      if (cmd_i.start) begin
        have_r <= 1'b0;
      end else if (better) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_idx_r  <= cmp_idx_r;
      best_size_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      out_found_r <= have_r;
      out_idx_r   <= have_r ? best_idx_r : '0;
      out_left_r  <= have_r ? left : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_alloc_index = out_idx_r;
  assign out_left_size   = out_left_r;

  `BFHA_ASSERT_NXT(a_cmp_follows_issue, cmd_i.issue, cmp_valid_r, "compare stage missed a read")
  `BFHA_ASSERT_IMP(a_no_fit_zero, out_valid_r && !out_found_r, (out_idx_r == '0) && (out_left_r == '0), "no-fit result not cleared")
  `BFHA_ASSERT_NXT(a_out_held, out_valid_r && !out_ready, out_valid_r, "result dropped")

endmodule

@@ design/best_fit_hole_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_hole_allocator
// Best-fit search over a table of free hole sizes, with load and request items.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_action, in_hole_index, in_size_value
//  out      out  out_valid/out_ready  out_found, out_alloc_index, out_left_size
//  cfg      in   cfg_valid/cfg_ready  cfg_data (hole_count)
//
// A load item writes the hole table when it is accepted. A request item sweeps
// the single read port of the hole table one entry per cycle over
// min(hole_count, 64) entries, then the last compare and the write-back follow;
// when hole_count is zero it goes straight to the result hand-off.
// The result register lets loads be accepted while a result waits; a request
// waits in its final cycle until the result register is free.
// Reset clears hole_count and the control state; the table needs no clearing.
// ----------------------------------------------------------------------------
module best_fit_hole_allocator
  import bfha_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  in_action,
  input  idx_t  in_hole_index,
  input  size_t in_size_value,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_found,
  output idx_t  out_alloc_index,
  output size_t out_left_size,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  cnt_t  cfg_data
);

  bfha_cmd_t  cmd;
  bfha_stat_t stat;

  assign cfg_ready = 1'b1;

  bfha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bfha_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .in_hole_index   (in_hole_index),
    .in_size_value   (in_size_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_alloc_index (out_alloc_index),
    .out_left_size   (out_left_size)
  );

endmodule

@@ tb/bfha_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// bfha_tb_pkg
// Item codes shared by the allocator stimulus and its checker.
// ----------------------------------------------------------------------------
package bfha_tb_pkg;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_REQUEST = 1'b1
  } action_e;

endpackage

@@ tb/hole_allocator_checker.sv @@
// ----------------------------------------------------------------------------
// hole_allocator_checker
// Keeps its own copy of the hole table and hole count, predicts the grant of
// every accepted request and compares each delivered result with the oldest one.
// ----------------------------------------------------------------------------
module hole_allocator_checker
  import bfha_pkg::*;
  import bfha_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [5:0]  in_hole_index,
  input  logic [15:0] in_size_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic [5:0]  out_alloc_index,
  input  logic [15:0] out_left_size,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          grants_outstanding
);

  typedef struct packed {
    logic  found;
    idx_t  index;
    size_t left;
  } grant_t;

  size_t  holes [HOLES];
  cnt_t   hole_count;
  grant_t grants_due [$];
  int     shown;
  grant_t want;

  initial begin
    fail_count = 0;
    grants_outstanding = 0;
    shown = 0;
    hole_count = '0;
  end

  // Smallest hole that fits, lowest index on a tie; the chosen hole shrinks.
  function automatic grant_t predict_grant(size_t need);
    grant_t g;
    int     span;
    g = '0;
    span = (hole_count > HOLES_CNT) ? HOLES : int'(hole_count);
    for (int i = 0; i < span; i++) begin
      if (holes[i] >= need && (!g.found || holes[i] < holes[g.index])) begin
        g.found = 1'b1;
        g.index = idx_t'(i);
      end
    end
    if (g.found) begin
      holes[g.index] = holes[g.index] - need;
      g.left = holes[g.index];
    end
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hole_count = '0;
      grants_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        hole_count = cfg_data;
      if (in_valid && in_ready) begin
        if (in_action == ACT_LOAD)
          holes[in_hole_index] = in_size_value;
        else
          grants_due.push_back(predict_grant(in_size_value));
      end
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("unexpected result: found=%0d index=%0d left=%0d",
                     out_found, out_alloc_index, out_left_size);
          end
        end else begin
          want = grants_due.pop_front();
          if (out_found !== want.found || out_alloc_index !== want.index ||
              out_left_size !== want.left) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("mismatch: expected found=%0d index=%0d left=%0d, got %0d %0d %0d",
                       want.found, want.index, want.left,
                       out_found, out_alloc_index, out_left_size);
            end
          end
        end
      end
    end
    grants_outstanding = grants_due.size();
  end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the best-fit hole allocator: a directed pass over empty ranges,
// ties, exact fits, zero requests and oversized counts, then random loads and
// requests under four phases of input idling and output stalls, with hole count changes while idle.
// ----------------------------------------------------------------------------
module tb;
  import bfha_pkg::*;
  import bfha_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 70;
  localparam int PHASE_ITEMS   = 143;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [5:0]  in_hole_index = '0;
  logic [15:0] in_size_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [5:0]  out_alloc_index;
  logic [15:0] out_left_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;

  int          fail_count;
  int          grants_outstanding;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_table [4] = '{0, 82, 0, 19};
  int unsigned stall_table [4] = '{0, 0, 82, 19};

  best_fit_hole_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_hole_index(in_hole_index), .in_size_value(in_size_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_alloc_index(out_alloc_index), .out_left_size(out_left_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  hole_allocator_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_hole_index(in_hole_index), .in_size_value(in_size_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_alloc_index(out_alloc_index), .out_left_size(out_left_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .grants_outstanding(grants_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Called and returns at a falling edge; the item is dropped once accepted.
  task automatic push_item(action_e act, idx_t idx, size_t size);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = act;
    in_hole_index = idx;
    in_size_value = size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // The count only changes with no request in flight.
  task automatic write_hole_count(cnt_t value);
    while (grants_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic size_t pick_size(bit for_request);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return size_t'($urandom_range(1023));
    if (r < 80) return size_t'($urandom_range(65535));
    if (r < 90) return for_request ? size_t'(0) : size_t'(16'hFFFF);
    return for_request ? size_t'(16'hFFFF) : size_t'(0);
  endfunction

  function automatic cnt_t pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return cnt_t'(0);
    if (r < 20) return cnt_t'(1);
    if (r < 35) return HOLES_CNT;
    if (r < 45) return cnt_t'($urandom_range(127, 65));
    return cnt_t'($urandom_range(63, 2));
  endfunction

  function automatic size_t fill_size(int i);
    if (i == 0) return size_t'(16'hFFFF);
    if (i == 5 || i == 9) return size_t'(100);
    if (i == HOLES - 1) return size_t'(0);
    return size_t'($urandom_range(60000, 1000));
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // No entries in use: nothing can fit.
    write_hole_count(cnt_t'(0));
    push_item(ACT_REQUEST, idx_t'(0), size_t'(0));
    push_item(ACT_REQUEST, idx_t'(63), size_t'(16'hFFFF));

    // Every entry is loaded before any request can scan it.
    for (int i = 0; i < HOLES; i++)
      push_item(ACT_LOAD, idx_t'(i), fill_size(i));

    write_hole_count(HOLES_CNT);
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(100));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(100));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(0));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(16'hFFFF));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(16'hFFFF));

    write_hole_count(cnt_t'(127));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(500));

    write_hole_count(cnt_t'(1));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(0));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(1));
    // A load past the count is still stored.
    push_item(ACT_LOAD, idx_t'(40), size_t'(7));

    write_hole_count(HOLES_CNT);
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(7));
    push_item(ACT_LOAD, idx_t'(63), size_t'(16'hFFFF));
    push_item(ACT_REQUEST, idx_t'($urandom_range(63)), size_t'(16'hFFFE));

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_table[p];
      stall_pct = stall_table[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 39)
          write_hole_count(pick_count());
        if ($urandom_range(99) < 50)
          push_item(ACT_LOAD, idx_t'($urandom_range(63)), pick_size(1'b0));
        else
          push_item(ACT_REQUEST, idx_t'($urandom_range(63)), pick_size(1'b1));
      end
    end

    while (grants_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && grants_outstanding == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
